// ===== hw/rtl/rsmm_pkg.sv =====
`default_nettype none

package rsmm_pkg;

    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int SUM_W  = 36;
    localparam int CFG_W  = 5;
    localparam int CIDX_W = 4;
    localparam int DIM_W  = 9;
    localparam int ADDR_W = 8;

    localparam logic [CIDX_W-1:0] REG_INNER_USED = 4'd0;
    localparam logic [CIDX_W-1:0] REG_COLS_USED  = 4'd1;

    localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_row;
        logic [ADDR_W-1:0] wr_col;
        logic [VAL_W-1:0]  wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_row;
        logic              mul_en;
        logic [VAL_W-1:0]  a_value;
        logic              mac_en;
        logic [DIM_W-1:0]  n_cols;
        logic              first;
        logic              load;
        logic              shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsmm_cell.sv =====
`default_nettype none

module rsmm_cell #(
    parameter int MAX_INNER = 16,
    parameter int COL       = 0
) (
    input  wire                             clk,
    input  wire rsmm_pkg::cell_ctrl_t       ctrl,
    input  wire  [rsmm_pkg::SUM_W-1:0]      shift_in,
    output logic [rsmm_pkg::SUM_W-1:0]      shift_out
);

    localparam int KW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

    logic [rsmm_pkg::VAL_W-1:0]  weight_mem [MAX_INNER];
    logic [rsmm_pkg::VAL_W-1:0]  w_reg;
    logic [rsmm_pkg::PROD_W-1:0] prod_reg;
    logic [rsmm_pkg::SUM_W-1:0]  acc_reg;
    logic [rsmm_pkg::SUM_W-1:0]  out_reg;
    logic [rsmm_pkg::SUM_W-1:0]  prod_ext;
    logic [rsmm_pkg::SUM_W-1:0]  acc_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && (ctrl.wr_col == rsmm_pkg::ADDR_W'(COL)))
        begin
            weight_mem[ctrl.wr_row[KW-1:0]] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            w_reg <= weight_mem[ctrl.rd_row[KW-1:0]];
        end
    end

    always_comb
    begin
        prod_ext = {{(rsmm_pkg::SUM_W - rsmm_pkg::PROD_W){prod_reg[rsmm_pkg::PROD_W-1]}},
                    prod_reg};
        acc_next = ctrl.first ? prod_ext : (acc_reg + prod_ext);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= rsmm_pkg::PROD_W'($signed(ctrl.a_value) * $signed(w_reg));
        end
        if (ctrl.mac_en && (rsmm_pkg::DIM_W'(COL) < ctrl.n_cols))
        begin
            acc_reg <= acc_next;
        end
        if (ctrl.load)
        begin
            out_reg <= acc_next;
        end
        else if (ctrl.shift)
        begin
            out_reg <= shift_in;
        end
    end

    assign shift_out = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/row_streamed_matrix_multiply.sv =====
`default_nettype none

// Row-streamed matrix multiply, C = A * B, Q4.12 operands, exact Q12.24 sums.
// Input stream (s_axis): tuser = func. func 0 writes one weight B[k][c];
// func 1 streams one left element A[row][k], rows in order, k from 0.
// Elements with k >= inner_used and writes outside the store are dropped.
// Output stream (m_axis): one transfer per used column after the last inner
// index of a row, column 0 first, tlast on the final column.
// Config channel (cfg_*): index 0 inner_used, 1 cols_used; write while idle.
// One column cell per result column, each with its own weight column, one
// multiplier and one accumulator; results shift out along the cell chain.
// Throughput: one input transfer per cycle. After the last element of a row
// the input stalls through the multiply/accumulate pipeline and the
// cols_used output transfers, longer if m_axis_tready is held low.
// The row's last element passes the s1 and s2 registers before its sums load into the output registers.
// Reset clears control state and sets both dimensions to 16; weights and
// accumulators keep no reset value. A receiver stall holds the result in
// cell 0 and freezes the chain.
module row_streamed_matrix_multiply #(
    parameter int MAX_INNER = 16,
    parameter int MAX_COLS  = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // inner_index[3:0], col_index[7:4], value[23:8]
    input  wire  [0:0]  s_axis_tuser,   // func[0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // result_col[3:0], sum[39:4]
    output logic        m_axis_tlast,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [3:0]  cfg_index,
    input  wire  [4:0]  cfg_data
);

    localparam logic [rsmm_pkg::DIM_W-1:0] MAX_INNER_V = rsmm_pkg::DIM_W'(MAX_INNER);
    localparam logic [rsmm_pkg::DIM_W-1:0] MAX_COLS_V  = rsmm_pkg::DIM_W'(MAX_COLS);

    logic [rsmm_pkg::CFG_W-1:0]  inner_cfg_reg;
    logic [rsmm_pkg::CFG_W-1:0]  cols_cfg_reg;
    logic [rsmm_pkg::DIM_W-1:0]  ninner;
    logic [rsmm_pkg::DIM_W-1:0]  ncols;

    logic                        in_func;
    logic [rsmm_pkg::DIM_W-1:0]  in_k;
    logic [rsmm_pkg::DIM_W-1:0]  in_c;
    logic [rsmm_pkg::VAL_W-1:0]  in_value;
    logic                        in_xfer;
    logic                        out_xfer;
    logic                        stream_ok;
    logic                        row_end;

    logic                        busy_reg;
    logic                        s1_valid_reg;
    logic                        s1_first_reg;
    logic                        s1_last_reg;
    logic [rsmm_pkg::VAL_W-1:0]  s1_a_reg;
    logic                        s2_valid_reg;
    logic                        s2_first_reg;
    logic                        s2_last_reg;
    logic [rsmm_pkg::DIM_W-1:0]  drain_cnt_reg;
    logic [rsmm_pkg::ADDR_W-1:0] col_reg;

    rsmm_pkg::cell_ctrl_t        ctrl;
    logic [rsmm_pkg::SUM_W-1:0]  chain [MAX_COLS+1];

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_cfg_reg <= rsmm_pkg::DIM_RESET;
            cols_cfg_reg  <= rsmm_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rsmm_pkg::REG_INNER_USED: inner_cfg_reg <= cfg_data;
                rsmm_pkg::REG_COLS_USED:  cols_cfg_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        if (inner_cfg_reg == '0)
            ninner = rsmm_pkg::DIM_W'(1);
        else if (rsmm_pkg::DIM_W'(inner_cfg_reg) > MAX_INNER_V)
            ninner = MAX_INNER_V;
        else
            ninner = rsmm_pkg::DIM_W'(inner_cfg_reg);

        if (cols_cfg_reg == '0)
            ncols = rsmm_pkg::DIM_W'(1);
        else if (rsmm_pkg::DIM_W'(cols_cfg_reg) > MAX_COLS_V)
            ncols = MAX_COLS_V;
        else
            ncols = rsmm_pkg::DIM_W'(cols_cfg_reg);
    end

    // input decode
    assign in_func  = s_axis_tuser[0];
    assign in_k     = rsmm_pkg::DIM_W'(s_axis_tdata[3:0]);
    assign in_c     = rsmm_pkg::DIM_W'(s_axis_tdata[7:4]);
    assign in_value = s_axis_tdata[23:8];

    assign s_axis_tready = !busy_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign stream_ok     = in_xfer && in_func && (in_k < ninner);
    assign row_end       = stream_ok && (in_k == (ninner - rsmm_pkg::DIM_W'(1)));
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            drain_cnt_reg <= '0;
            col_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= stream_ok;
            s2_valid_reg <= s1_valid_reg;
            if (row_end)
            begin
                busy_reg <= 1'b1;
            end
            else if (out_xfer && (drain_cnt_reg == rsmm_pkg::DIM_W'(1)))
            begin
                busy_reg <= 1'b0;
            end
            if (s2_valid_reg && s2_last_reg)
            begin
                drain_cnt_reg <= ncols;
                col_reg       <= '0;
            end
            else if (out_xfer)
            begin
                drain_cnt_reg <= drain_cnt_reg - rsmm_pkg::DIM_W'(1);
                col_reg       <= col_reg + rsmm_pkg::ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= (in_k == '0);
        s1_last_reg  <= row_end;
        s1_a_reg     <= in_value;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
    end

    // cell control
    always_comb
    begin
        ctrl.wr_en   = in_xfer && !in_func && (in_k < MAX_INNER_V) && (in_c < MAX_COLS_V);
        ctrl.wr_row  = in_k[rsmm_pkg::ADDR_W-1:0];
        ctrl.wr_col  = in_c[rsmm_pkg::ADDR_W-1:0];
        ctrl.wr_data = in_value;
        ctrl.rd_en   = stream_ok;
        ctrl.rd_row  = in_k[rsmm_pkg::ADDR_W-1:0];
        ctrl.mul_en  = s1_valid_reg;
        ctrl.a_value = s1_a_reg;
        ctrl.mac_en  = s2_valid_reg;
        ctrl.n_cols  = ncols;
        ctrl.first   = s2_first_reg;
        ctrl.load    = s2_valid_reg && s2_last_reg;
        ctrl.shift   = out_xfer;
    end

    assign chain[MAX_COLS] = '0;

    for (genvar j = 0; j < MAX_COLS; j++)
    begin : g_cell
        rsmm_cell #(
            .MAX_INNER (MAX_INNER),
            .COL       (j)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .shift_in  (chain[j+1]),
            .shift_out (chain[j])
        );
    end

    // output
    assign m_axis_tvalid = (drain_cnt_reg != '0);
    assign m_axis_tdata  = {chain[0], col_reg[3:0]};
    assign m_axis_tlast  = (drain_cnt_reg == rsmm_pkg::DIM_W'(1));

`ifndef SYNTHESIS
    a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_last_reg) |-> (drain_cnt_reg == '0))
        else $error("row loaded while results still draining");

    a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input open while results drain");

    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("result after last of row");

    a_row_end_pipeline: assert property (@(posedge clk) disable iff (!rst_n)
        row_end |=> ##1 (s2_valid_reg && s2_last_reg))
        else $error("row end lost in pipeline");
`endif

endmodule

`default_nettype wire
